// ===== design/tbh_pkg.sv =====
package tbh_pkg;

    // Fixed field widths
    localparam int TIME_W      = 64;
    localparam int BW_W        = 63;
    localparam int IDX_IN_W    = 10;
    localparam int STATUS_W    = 3;
    localparam int OUT_HITS_W  = 32;
    localparam int USE_W       = 11;
    localparam int CFG_IDX_W   = 8;
    localparam int STEP_W      = $clog2(TIME_W);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = CFG_IDX_W'(2);

    // Request modes
    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED   = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_READ_OK   = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_CLEARED   = 3'd4
    } tbh_status_t;

    typedef enum logic [2:0] {
        OP_RECORD,
        OP_READ,
        OP_CLEAR,
        OP_BAD,
        OP_RECALC
    } tbh_op_t;

    // One queued command
    typedef struct packed {
        tbh_op_t               op;
        logic                  window_ok;  // record: t >= start; recalc: start < end; bw != 0
        logic [TIME_W-1:0]     operand;    // record: time - start; recalc: end - start
        logic [BW_W-1:0]       divisor;    // bucket width
        logic [TIME_W-1:0]     base;       // window start
        logic [IDX_IN_W-1:0]   index;      // read bucket
    } tbh_cmd_t;

    // Back part to front part
    typedef struct packed {
        logic pop;
        logic init_active;
    } tbh_back_ctl_t;

endpackage

// ===== design/time_bin_histogram_core.sv =====
// Channel   Handshake                 Payload
// request   start in, busy out        mode, event_time, query_index
// result    done out (no backpressure) status, slot_start, slot_hits, slots_in_use
// config    cfg_valid in, cfg_ready out  cfg_index, cfg_data
//
// Record: the bucket is found by the 64-step radix-2 divider.
// Read: counter RAM read, then start-time add. Clear: a pass that zeroes every counter.
// A write to a defined register recomputes the bucket count on the same divider.
// After reset a clearing pass zeroes the counters; busy is high.
// A two-entry queue lets requests land while the back end works; results are never stalled.
module time_bin_histogram_core import tbh_pkg::*; #(
    parameter int MAX_BUCKETS = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic signed [TIME_W-1:0]  event_time,
    input  logic [IDX_IN_W-1:0]       query_index,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic signed [TIME_W-1:0]  slot_start,
    output logic [OUT_HITS_W-1:0]     slot_hits,
    output logic [USE_W-1:0]          slots_in_use,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [TIME_W-1:0]         cfg_data
);

    logic          head_valid;
    tbh_cmd_t      head;
    tbh_back_ctl_t back_ctl;

    // Intake, config registers and command queue
    tbh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .event_time  (event_time),
        .query_index (query_index),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .back_ctl    (back_ctl),
        .busy        (busy),
        .cfg_ready   (cfg_ready),
        .head_valid  (head_valid),
        .head        (head)
    );

    // Divider, counter store and result
    tbh_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .back_ctl     (back_ctl),
        .done         (done),
        .status       (status),
        .slot_start   (slot_start),
        .slot_hits    (slot_hits),
        .slots_in_use (slots_in_use)
    );

endmodule

// ===== design/tbh_ram.sv =====
module tbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tbh_div.sv =====
module tbh_div import tbh_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [TIME_W-1:0] dividend,
    input  logic [BW_W-1:0]   divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient,
    output logic              rem_nonzero
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [BW_W-1:0]   rem_reg;
    logic [TIME_W-1:0] qr_reg;
    logic [BW_W-1:0]   dvs_reg;

    logic [BW_W:0]     trial;
    logic              fits;
    logic [BW_W:0]     diff;

    // One quotient bit per cycle, restoring
    assign trial = {rem_reg, qr_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            qr_reg   <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                qr_reg   <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[BW_W-1:0] : trial[BW_W-1:0];
                qr_reg   <= {qr_reg[TIME_W-2:0], fits};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done        = done_reg;
    assign quotient    = qr_reg;
    assign rem_nonzero = rem_reg != '0;

endmodule

// ===== design/tbh_front.sv =====
module tbh_front import tbh_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 mode,
    input  logic signed [TIME_W-1:0]   event_time,
    input  logic [IDX_IN_W-1:0]        query_index,
    input  logic                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [TIME_W-1:0]          cfg_data,
    input  tbh_back_ctl_t              back_ctl,
    output logic                       busy,
    output logic                       cfg_ready,
    output logic                       head_valid,
    output tbh_cmd_t                   head
);

    logic signed [TIME_W-1:0] ws_reg, ws_next;
    logic signed [TIME_W-1:0] we_reg, we_next;
    logic [BW_W-1:0]          bw_reg, bw_next;

    tbh_cmd_t                 entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]        count_reg;

    logic                     has_space;
    logic                     item_accept;
    logic                     cfg_accept;
    logic                     cfg_hit;
    logic                     push;
    tbh_cmd_t                 item_cmd;
    tbh_cmd_t                 recalc_cmd;
    tbh_cmd_t                 push_cmd;

    // Handshakes
    assign has_space   = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign busy        = !has_space || back_ctl.init_active;
    assign item_accept = start && !busy;
    assign cfg_ready   = has_space && !item_accept;
    assign cfg_accept  = cfg_valid && cfg_ready;

    // Register file next values
    always_comb
    begin
        ws_next = ws_reg;
        we_next = we_reg;
        bw_next = bw_reg;
        cfg_hit = 1'b0;
        if (cfg_accept)
        begin
            case (cfg_index)
                REG_WINDOW_START:
                begin
                    ws_next = cfg_data;
                    cfg_hit = 1'b1;
                end
                REG_WINDOW_END:
                begin
                    we_next = cfg_data;
                    cfg_hit = 1'b1;
                end
                REG_BIN_WIDTH:
                begin
                    bw_next = cfg_data[BW_W-1:0];
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Classify an incoming request
    always_comb
    begin
        item_cmd.window_ok = !(event_time < ws_reg) && (bw_reg != '0);
        item_cmd.operand   = event_time - ws_reg;
        item_cmd.divisor   = bw_reg;
        item_cmd.base      = ws_reg;
        item_cmd.index     = query_index;
        case (mode)
            MODE_RECORD: item_cmd.op = OP_RECORD;
            MODE_READ:   item_cmd.op = OP_READ;
            MODE_CLEAR:  item_cmd.op = OP_CLEAR;
            default:     item_cmd.op = OP_BAD;
        endcase
    end

    // Bucket count recompute after a register write
    always_comb
    begin
        recalc_cmd.op        = OP_RECALC;
        recalc_cmd.window_ok = (ws_next < we_next) && (bw_next != '0);
        recalc_cmd.operand   = we_next - ws_next;
        recalc_cmd.divisor   = bw_next;
        recalc_cmd.base      = ws_next;
        recalc_cmd.index     = '0;
    end

    assign push     = item_accept || cfg_hit;
    assign push_cmd = item_accept ? item_cmd : recalc_cmd;

    // Config registers and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= '0;
            we_reg     <= '0;
            bw_reg     <= BW_W'(1);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            ws_reg <= ws_next;
            we_reg <= we_next;
            bw_reg <= bw_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (back_ctl.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, back_ctl.pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

endmodule

// ===== design/tbh_back.sv =====
module tbh_back import tbh_pkg::*; #(
    parameter int MAX_BUCKETS = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  tbh_cmd_t               head,
    output tbh_back_ctl_t          back_ctl,
    output logic                   done,
    output logic [STATUS_W-1:0]    status,
    output logic [TIME_W-1:0]      slot_start,
    output logic [OUT_HITS_W-1:0]  slot_hits,
    output logic [USE_W-1:0]       slots_in_use
);

    localparam int AW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SLOT_W = $clog2(MAX_BUCKETS + 1);
    localparam int CMP_W  = (SLOT_W > IDX_IN_W) ? SLOT_W : IDX_IN_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_INC,
        S_READ
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           sweep_reg;
    logic [SLOT_W-1:0]       slots_reg;
    tbh_op_t                 op_reg;
    logic [AW-1:0]           addr_reg;
    logic [TIME_W-1:0]       base_reg;
    logic [TIME_W-1:0]       prod_reg;
    logic                    done_reg;
    tbh_status_t             status_reg;
    logic [TIME_W-1:0]       start_reg;
    logic [OUT_HITS_W-1:0]   hits_reg;
    logic [USE_W-1:0]        use_reg;

    logic                    pop;
    logic                    slots_nz;
    logic                    qi_ok;
    logic                    div_go;
    logic                    div_done;
    logic [TIME_W-1:0]       quot;
    logic                    rem_nz;
    logic                    rec_ok;
    logic [TIME_W:0]         q_up;
    logic [SLOT_W-1:0]       slots_calc;
    logic                    sweep_last;
    logic [BW_W+IDX_IN_W-1:0] prod_full;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [OUT_HITS_W-1:0]   hits_out;
    logic [USE_W-1:0]        use_now;

    // Dispatch decisions
    assign pop        = (state_reg == S_IDLE) && head_valid;
    assign slots_nz   = slots_reg != '0;
    assign qi_ok      = CMP_W'(head.index) < CMP_W'(slots_reg);
    assign div_go     = pop && head.window_ok &&
                        (((head.op == OP_RECORD) && slots_nz) || (head.op == OP_RECALC));
    assign prod_full  = head.divisor * head.index;

    assign back_ctl.pop         = pop;
    assign back_ctl.init_active = state_reg == S_INIT;

    // Shared divider: bucket index of a record and bucket count of a recompute
    tbh_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (div_go),
        .dividend    (head.operand),
        .divisor     (head.divisor),
        .done        (div_done),
        .quotient    (quot),
        .rem_nonzero (rem_nz)
    );

    assign rec_ok     = quot < TIME_W'(slots_reg);
    assign q_up       = {1'b0, quot} + (TIME_W + 1)'(rem_nz);
    assign slots_calc = (q_up > (TIME_W + 1)'(MAX_BUCKETS)) ? SLOT_W'(MAX_BUCKETS)
                                                             : SLOT_W'(q_up);
    assign sweep_last = sweep_reg == AW'(MAX_BUCKETS - 1);

    // Counter memory ports
    assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
    assign hits_out  = OUT_HITS_W'(ram_rdata);
    assign use_now   = USE_W'(slots_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = count_inc;
        ram_raddr = (state_reg == S_DIV) ? AW'(quot) : AW'(head.index);
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
            end
            S_INC:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tbh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BUCKETS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            sweep_reg  <= '0;
            slots_reg  <= '0;
            op_reg     <= OP_BAD;
            addr_reg   <= '0;
            base_reg   <= '0;
            prod_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_BAD_INDEX;
            start_reg  <= '0;
            hits_reg   <= '0;
            use_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_last)
                    begin
                        sweep_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (pop)
                    begin
                        op_reg   <= head.op;
                        base_reg <= head.base;
                        prod_reg <= TIME_W'(prod_full);
                        addr_reg <= AW'(head.index);
                        case (head.op)
                            OP_RECORD:
                            begin
                                if (div_go)
                                begin
                                    state_reg <= S_DIV;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_DROPPED;
                                    start_reg  <= '0;
                                    hits_reg   <= '0;
                                    use_reg    <= use_now;
                                end
                            end
                            OP_READ:
                            begin
                                if (qi_ok)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_BAD_INDEX;
                                    start_reg  <= '0;
                                    hits_reg   <= '0;
                                    use_reg    <= use_now;
                                end
                            end
                            OP_CLEAR:
                            begin
                                sweep_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            OP_RECALC:
                            begin
                                if (div_go)
                                begin
                                    state_reg <= S_DIV;
                                end
                                else
                                begin
                                    slots_reg <= '0;
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_BAD_INDEX;
                                start_reg  <= '0;
                                hits_reg   <= '0;
                                use_reg    <= use_now;
                            end
                        endcase
                    end
                end

                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                    if (sweep_last)
                    begin
                        sweep_reg  <= '0;
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        status_reg <= ST_CLEARED;
                        start_reg  <= '0;
                        hits_reg   <= '0;
                        use_reg    <= use_now;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (op_reg == OP_RECALC)
                        begin
                            slots_reg <= slots_calc;
                            state_reg <= S_IDLE;
                        end
                        else if (rec_ok)
                        begin
                            // counter read issued this cycle, updated next
                            addr_reg  <= AW'(quot);
                            state_reg <= S_INC;
                        end
                        else
                        begin
                            state_reg  <= S_IDLE;
                            done_reg   <= 1'b1;
                            status_reg <= ST_DROPPED;
                            start_reg  <= '0;
                            hits_reg   <= '0;
                            use_reg    <= use_now;
                        end
                    end
                end

                S_INC:
                begin
                    state_reg  <= S_IDLE;
                    done_reg   <= 1'b1;
                    status_reg <= ST_COUNTED;
                    start_reg  <= '0;
                    hits_reg   <= '0;
                    use_reg    <= use_now;
                end

                S_READ:
                begin
                    state_reg  <= S_IDLE;
                    done_reg   <= 1'b1;
                    status_reg <= ST_READ_OK;
                    start_reg  <= base_reg + prod_reg;
                    hits_reg   <= hits_out;
                    use_reg    <= use_now;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_start   = start_reg;
    assign slot_hits    = hits_reg;
    assign slots_in_use = use_reg;

endmodule

// ===== design/tbh_checker.sv =====
module tbh_checker import tbh_pkg::*; #(
    parameter int MAX_BUCKETS = 1024
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [STATUS_W-1:0]       status,
    input logic signed [TIME_W-1:0]  slot_start,
    input logic [OUT_HITS_W-1:0]     slot_hits,
    input logic [USE_W-1:0]          slots_in_use,
    input logic                      cfg_ready
);

    // Only the five defined result codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_COUNTED || status == ST_DROPPED || status == ST_READ_OK ||
                  status == ST_BAD_INDEX || status == ST_CLEARED))
        else $error("undefined result status");

    // Bucket data only on a good read
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_READ_OK) |-> (slot_start == '0 && slot_hits == '0))
        else $error("bucket fields set on a non-read result");

    // Bucket count never above the store size
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (MAX_BUCKETS >= 2048 || 32'(slots_in_use) <= MAX_BUCKETS))
        else $error("bucket count above store size");

    // A counted event or good read needs at least one bucket
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_COUNTED || status == ST_READ_OK)) |->
            (MAX_BUCKETS >= 2048 || slots_in_use != '0))
        else $error("bucket hit with an empty histogram");

    // No register write is taken on an edge that takes a request
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !cfg_ready)
        else $error("register write open while a request is taken");

endmodule

bind time_bin_histogram_core tbh_checker #(.MAX_BUCKETS(MAX_BUCKETS)) u_tbh_checker (.*);

// ===== dv/time_bin_histogram_core_test.sv =====
`timescale 1ns / 1ps

module time_bin_histogram_core_test;
    import tbh_pkg::*;

    localparam int          BUCKETS       = 1024;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        HOP_REQ,
        HOP_CFG,
        HOP_SYNC
    } host_kind_t;

    // One entry of the host plan: a request, a register write or a sync point
    typedef struct {
        host_kind_t            kind;
        logic [1:0]            mode;
        logic [TIME_W-1:0]     ev_time;
        logic [IDX_IN_W-1:0]   qidx;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [TIME_W-1:0]     reg_data;
    } host_op_t;

    typedef struct {
        tbh_status_t           status;
        logic [TIME_W-1:0]     slot_start;
        logic [OUT_HITS_W-1:0] slot_hits;
        logic [USE_W-1:0]      slots_in_use;
    } bin_report_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                mode = MODE_RECORD;
    logic signed [TIME_W-1:0]  event_time = '0;
    logic [IDX_IN_W-1:0]       query_index = '0;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic signed [TIME_W-1:0]  slot_start;
    logic [OUT_HITS_W-1:0]     slot_hits;
    logic [USE_W-1:0]          slots_in_use;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [TIME_W-1:0]         cfg_data = '0;

    host_op_t                  host_ops[$];
    bin_report_t               bin_reports_due[$];
    int                        fail_count = 0;
    int                        sync_wait = 0;
    int                        reqs_sent = 0;

    // Histogram mirror: window registers, bucket count and counters
    logic [TIME_W-1:0]         win_start;
    logic [TIME_W-1:0]         win_end;
    logic [BW_W-1:0]           win_width;
    int unsigned               win_slots;
    logic [OUT_HITS_W-1:0]     bin_hits[BUCKETS];

    // Window registers as the plan will have set them, for shaping stimulus
    logic [TIME_W-1:0]         plan_start;
    logic [TIME_W-1:0]         plan_end;
    logic [BW_W-1:0]           plan_width;

    time_bin_histogram_core #(
        .MAX_BUCKETS(BUCKETS),
        .COUNT_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .event_time(event_time),
        .query_index(query_index),
        .done(done),
        .status(status),
        .slot_start(slot_start),
        .slot_hits(slot_hits),
        .slots_in_use(slots_in_use),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ceil((end - start) / width), zero for an empty window or zero width, clamped to BUCKETS
    function automatic int unsigned bucket_count(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                                                 logic [BW_W-1:0] w);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] q;
        logic [TIME_W-1:0] wd;
        if (w == '0 || !($signed(s) < $signed(e)))
            return 0;
        wd = {1'b0, w};
        span = e - s;
        q = span / wd;
        if (span % wd != '0)
            q = q + 1;
        if (q > TIME_W'(BUCKETS))
            q = TIME_W'(BUCKETS);
        return q[31:0];
    endfunction

    function automatic void apply_window_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] d);
        case (idx)
            REG_WINDOW_START: win_start = d;
            REG_WINDOW_END:   win_end = d;
            REG_BIN_WIDTH:    win_width = d[BW_W-1:0];
            default:          return;
        endcase
        win_slots = bucket_count(win_start, win_end, win_width);
    endfunction

    // Expected report for one request; updates the counters
    function automatic bin_report_t predict_bin_report(logic [1:0] m, logic [TIME_W-1:0] t,
                                                       logic [IDX_IN_W-1:0] q);
        bin_report_t       r;
        logic [TIME_W-1:0] idx;
        r.status = ST_BAD_INDEX;
        r.slot_start = '0;
        r.slot_hits = '0;
        r.slots_in_use = win_slots[USE_W-1:0];
        case (m)
            MODE_RECORD:
            begin
                r.status = ST_DROPPED;
                if (win_slots != 0 && win_width != '0 && !($signed(t) < $signed(win_start)))
                begin
                    idx = (t - win_start) / {1'b0, win_width};
                    if (idx < TIME_W'(win_slots))
                    begin
                        if (bin_hits[idx[IDX_IN_W-1:0]] != '1)
                            bin_hits[idx[IDX_IN_W-1:0]] = bin_hits[idx[IDX_IN_W-1:0]] + 1;
                        r.status = ST_COUNTED;
                    end
                end
            end
            MODE_READ:
            begin
                if (32'(q) < win_slots)
                begin
                    r.status = ST_READ_OK;
                    r.slot_start = win_start + {1'b0, win_width} * TIME_W'(q);
                    r.slot_hits = bin_hits[q];
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < BUCKETS; i++)
                    bin_hits[i] = '0;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Plan builders
    task automatic plan_req(logic [1:0] m, logic [TIME_W-1:0] t, logic [IDX_IN_W-1:0] q);
        host_op_t op;
        op.kind = HOP_REQ;
        op.mode = m;
        op.ev_time = t;
        op.qidx = q;
        op.reg_idx = '0;
        op.reg_data = '0;
        host_ops.push_back(op);
    endtask

    task automatic plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] d);
        host_op_t op;
        op.kind = HOP_CFG;
        op.mode = MODE_RECORD;
        op.ev_time = '0;
        op.qidx = '0;
        op.reg_idx = idx;
        op.reg_data = d;
        host_ops.push_back(op);
        case (idx)
            REG_WINDOW_START: plan_start = d;
            REG_WINDOW_END:   plan_end = d;
            REG_BIN_WIDTH:    plan_width = d[BW_W-1:0];
            default: ;
        endcase
    endtask

    // Sender pauses here until every report is in, then settles
    task automatic plan_sync();
        host_op_t op;
        op.kind = HOP_SYNC;
        op.mode = MODE_RECORD;
        op.ev_time = '0;
        op.qidx = '0;
        op.reg_idx = '0;
        op.reg_data = '0;
        host_ops.push_back(op);
    endtask

    // Event time: mostly inside or near the window, some edges, some anywhere
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned       nb;
        int unsigned       r;
        logic [TIME_W-1:0] reach;
        nb = bucket_count(plan_start, plan_end, plan_width);
        r = $urandom_range(99);
        reach = {1'b0, plan_width} * TIME_W'(nb + 1);
        if (r < 15 || nb == 0 || reach == '0)
            return rand64();
        if (r < 30)
        begin
            case ($urandom_range(5))
                0: return plan_start - 1;
                1: return plan_start;
                2: return plan_start + {1'b0, plan_width} * TIME_W'(nb) - 1;
                3: return plan_start + {1'b0, plan_width} * TIME_W'(nb);
                4: return plan_end - 1;
                default: return plan_end;
            endcase
        end
        if (r < 38)
            return plan_start - TIME_W'($urandom_range(1, 1000));
        return plan_start + rand64() % reach;
    endfunction

    function automatic logic [IDX_IN_W-1:0] pick_index();
        int unsigned nb;
        int unsigned r;
        nb = bucket_count(plan_start, plan_end, plan_width);
        r = $urandom_range(99);
        if (nb != 0 && r < 70)
            return IDX_IN_W'($urandom_range(nb - 1));
        if (nb < BUCKETS && r < 80)
            return IDX_IN_W'(nb);
        return IDX_IN_W'($urandom_range(BUCKETS - 1));
    endfunction

    // New window setting, registers written in random order
    task automatic plan_window(int kind);
        logic [TIME_W-1:0]    s;
        logic [TIME_W-1:0]    e;
        logic [BW_W-1:0]      w;
        int unsigned          wi;
        logic [CFG_IDX_W-1:0] ord[3];
        logic [CFG_IDX_W-1:0] tmp;
        int unsigned          j;
        s = {{32{1'b0}}, $urandom()};
        s = {{32{s[31]}}, s[31:0]};
        case (kind)
            0:
            begin
                wi = $urandom_range(1, 300);
                w = BW_W'(wi);
                e = s + TIME_W'(wi) * TIME_W'($urandom_range(1, 60))
                    - TIME_W'($urandom_range(wi - 1));
            end
            1:
            begin
                wi = $urandom_range(1, 3);
                w = BW_W'(wi);
                e = s + TIME_W'(wi) * TIME_W'($urandom_range(BUCKETS, 5000));
            end
            2:
            begin
                w = '0;
                e = s + TIME_W'($urandom_range(1, 5000));
            end
            3:
            begin
                w = BW_W'($urandom_range(1, 100));
                e = s - TIME_W'($urandom_range(0, 1000));
            end
            4:
            begin
                s = rand64();
                e = rand64();
                w = rand64();
            end
            default:
            begin
                s = rand64();
                w = BW_W'(rand64() >> $urandom_range(8, 50));
                e = s + {1'b0, w} * TIME_W'($urandom_range(1, 20));
            end
        endcase
        ord[0] = REG_WINDOW_START;
        ord[1] = REG_WINDOW_END;
        ord[2] = REG_BIN_WIDTH;
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = ord[i];
            ord[i] = ord[j];
            ord[j] = tmp;
        end
        for (int i = 0; i < 3; i++)
        begin
            case (ord[i])
                REG_WINDOW_START: plan_cfg(REG_WINDOW_START, s);
                REG_WINDOW_END:   plan_cfg(REG_WINDOW_END, e);
                default:          plan_cfg(REG_BIN_WIDTH, {1'($urandom_range(1)), w});
            endcase
        end
        if ($urandom_range(99) < 30)
            plan_cfg(CFG_IDX_W'($urandom_range(3, 255)), rand64());
    endtask

    task automatic plan_random_req();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 78)
            plan_req(MODE_RECORD, pick_time(), IDX_IN_W'($urandom_range(BUCKETS - 1)));
        else if (r < 93)
            plan_req(MODE_READ, rand64(), pick_index());
        else if (r < 96)
            plan_req(MODE_CLEAR, rand64(), IDX_IN_W'($urandom_range(BUCKETS - 1)));
        else
            plan_req(MODE_UNUSED, rand64(), IDX_IN_W'($urandom_range(BUCKETS - 1)));
    endtask

    // Sender idles about a third of the time, except for one long stretch
    function automatic bit take_break();
        if (reqs_sent >= 200 && reqs_sent < 320)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    // Request and register-write driver; predicts on each accepted request
    always @(posedge clk or negedge rst_n)
    begin : host_driver
        logic     req_on;
        logic     cfg_on;
        host_op_t op;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            win_start = '0;
            win_end = '0;
            win_width = BW_W'(1);
            win_slots = bucket_count(win_start, win_end, win_width);
            for (int i = 0; i < BUCKETS; i++)
                bin_hits[i] = '0;
        end
        else
        begin
            req_on = start;
            cfg_on = cfg_valid;
            if (start && !busy)
            begin
                bin_reports_due.push_back(predict_bin_report(mode, event_time, query_index));
                req_on = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_window_reg(cfg_index, cfg_data);
                cfg_on = 1'b0;
            end
            if (!req_on && !cfg_on && host_ops.size() != 0)
            begin
                if (host_ops[0].kind == HOP_SYNC)
                begin
                    if (bin_reports_due.size() != 0)
                        sync_wait = 0;
                    else if (sync_wait >= SETTLE_CYCLES)
                    begin
                        void'(host_ops.pop_front());
                        sync_wait = 0;
                    end
                    else
                        sync_wait++;
                end
                else if (!take_break())
                begin
                    op = host_ops.pop_front();
                    if (op.kind == HOP_REQ)
                    begin
                        req_on = 1'b1;
                        mode <= op.mode;
                        event_time <= op.ev_time;
                        query_index <= op.qidx;
                        reqs_sent++;
                    end
                    else
                    begin
                        cfg_on = 1'b1;
                        cfg_index <= op.reg_idx;
                        cfg_data <= op.reg_data;
                    end
                end
            end
            start <= req_on;
            cfg_valid <= cfg_on;
        end
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        bin_report_t want;
        if (rst_n && done)
        begin
            if (bin_reports_due.size() == 0)
            begin
                $error("unexpected report: status %0d slot_start %0d slot_hits %0d",
                       status, slot_start, slot_hits);
                fail_count++;
            end
            else
            begin
                want = bin_reports_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (slot_start !== want.slot_start)
                begin
                    $error("slot_start: expected %0d, got %0d",
                           $signed(want.slot_start), slot_start);
                    fail_count++;
                end
                if (slot_hits !== want.slot_hits)
                begin
                    $error("slot_hits: expected %0d, got %0d", want.slot_hits, slot_hits);
                    fail_count++;
                end
                if (slots_in_use !== want.slots_in_use)
                begin
                    $error("slots_in_use: expected %0d, got %0d",
                           want.slots_in_use, slots_in_use);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus plan, reset and end of run
    initial
    begin : run_ctl
        int random_left;
        int phase;
        int chunk;
        plan_start = '0;
        plan_end = '0;
        plan_width = BW_W'(1);

        // Empty histogram after reset, unused mode, clear
        plan_req(MODE_RECORD, '0, '0);
        plan_req(MODE_READ, rand64(), '0);
        plan_req(MODE_UNUSED, 64'h7FFF_FFFF_FFFF_FFFF, '1);
        plan_req(MODE_CLEAR, rand64(), '0);

        // Nine buckets, the last one running past the window end
        plan_sync();
        plan_cfg(REG_WINDOW_START, 64'd100);
        plan_cfg(REG_WINDOW_END, 64'd950);
        plan_cfg(REG_BIN_WIDTH, 64'd100);
        plan_req(MODE_RECORD, 64'd99, '0);
        plan_req(MODE_RECORD, 64'd100, '0);
        plan_req(MODE_RECORD, 64'd199, '0);
        plan_req(MODE_RECORD, 64'd990, '0);
        plan_req(MODE_RECORD, 64'd1000, '0);
        plan_req(MODE_RECORD, 64'h8000_0000_0000_0000, '0);
        plan_req(MODE_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        plan_req(MODE_READ, '0, 10'd0);
        plan_req(MODE_READ, '0, 10'd8);
        plan_req(MODE_READ, '0, 10'd9);
        plan_req(MODE_CLEAR, '0, '0);
        plan_req(MODE_READ, '0, 10'd0);

        // Full signed range, widest bucket, plus writes to unused indexes
        plan_sync();
        plan_cfg(REG_WINDOW_START, 64'h8000_0000_0000_0000);
        plan_cfg(REG_WINDOW_END, 64'h7FFF_FFFF_FFFF_FFFF);
        plan_cfg(REG_BIN_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_cfg(CFG_IDX_W'(3), rand64());
        plan_cfg('1, rand64());
        plan_req(MODE_RECORD, 64'h8000_0000_0000_0000, '0);
        plan_req(MODE_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        plan_req(MODE_RECORD, '0, '0);
        plan_req(MODE_READ, '0, 10'd2);
        plan_req(MODE_READ, '0, 10'd3);

        // Zero width empties the histogram
        plan_sync();
        plan_cfg(REG_BIN_WIDTH, '0);
        plan_req(MODE_RECORD, 64'h8000_0000_0000_0001, '0);
        plan_req(MODE_READ, '0, '0);

        // Random phases, each under a new window setting
        random_left = 480;
        phase = 0;
        while (random_left > 0)
        begin
            plan_sync();
            plan_window(phase % 6);
            chunk = $urandom_range(30, 80);
            for (int i = 0; i < chunk && random_left > 0; i++)
            begin
                if ($urandom_range(99) < 2)
                    plan_sync();
                plan_random_req();
                random_left--;
            end
            phase++;
        end
        plan_sync();

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (host_ops.size() != 0 || start || cfg_valid)
            @(posedge clk);
        if (bin_reports_due.size() != 0)
        begin
            $error("%0d reports never arrived", bin_reports_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("time_bin_histogram_core_test: done, clean");
        else
            $display("time_bin_histogram_core_test: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("time_bin_histogram_core_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tbh_pkg.sv
design/tbh_ram.sv
design/tbh_div.sv
design/tbh_front.sv
design/tbh_back.sv
design/time_bin_histogram_core.sv
design/tbh_checker.sv
dv/time_bin_histogram_core_test.sv
